>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/mqfc_pkg.sv
package mqfc_pkg;

  localparam int NUM_QUEUES_DEF  = 3;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ID_WIDTH_DEF    = 32;

  localparam logic [1:0] MODE_ENQ    = 2'd0;
  localparam logic [1:0] MODE_PRINT  = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  printer;
    logic [31:0] doc_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] printed_doc;
    logic [3:0]  queue_length;
  } out_item_t;

endpackage

>>> sv/mqfc_ram.sv
module mqfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/multi_queue_fifo_with_cancel_unit.sv
// Enqueue, clear and an out-of-range printer go from accept through S_EXEC and S_DONE to out_valid;
// print and cancel on a non-empty queue pass through S_SCAN between S_EXEC and S_DONE.
// One word at a time: in_ready returns with out_valid; an unaccepted result holds the next in S_DONE.
// Print and cancel walk the queue through the read port of the entry RAM, one per cycle.
// Reset (rst_n, synchronous): all queues empty, no result pending; no clearing pass.
`include "assert_macros.svh"

module multi_queue_fifo_with_cancel_unit #(
  parameter int NUM_QUEUES  = mqfc_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqfc_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = mqfc_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mqfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mqfc_pkg::out_item_t out_data
);

  localparam int DEPTH_TOT = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH_TOT);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  logic                q_ok_r, q_ok_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [KW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                found_r, found_nxt;
  logic [ID_WIDTH-1:0] taken_r, taken_nxt;
  mqfc_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  mqfc_pkg::out_item_t out_data_r, out_data_nxt;
  logic [CW-1:0]       cnt_r [NUM_QUEUES];

  logic                cnt_we;
  logic [CW-1:0]       cnt_wdata;
  logic [CW-1:0]       cnt_cur;
  logic [AW-1:0]       base;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ID_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ID_WIDTH-1:0] ram_rdata;
  logic                hit;
  logic                found_now;
  logic                scan_done;
  logic [ID_WIDTH-1:0] head_id;

  assign cnt_cur   = q_ok_r ? cnt_r[q_r] : '0;
  assign base      = AW'(int'(q_r) * QUEUE_DEPTH);
  assign ram_raddr = base + AW'(k_r[KW-1:0]);
  assign hit       = rd_vld_r && !found_r &&
                     ((ram_rdata == id_r) || (mode_r == mqfc_pkg::MODE_PRINT));
  assign found_now = found_r || hit;
  assign scan_done = rd_vld_r && (k_r == cnt_cur);
  assign head_id   = hit ? ram_rdata : taken_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mqfc_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(DEPTH_TOT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    q_nxt         = q_r;
    q_ok_nxt      = q_ok_r;
    id_nxt        = id_r;
    k_nxt         = k_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    taken_nxt     = taken_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cnt_we        = 1'b0;
    cnt_wdata     = '0;
    ram_we        = 1'b0;
    ram_waddr     = base + AW'(cnt_cur[KW-1:0]);
    ram_wdata     = id_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          q_nxt     = QW'(in_data.printer);
          q_ok_nxt  = (32'(in_data.printer) < NUM_QUEUES);
          id_nxt    = ID_WIDTH'(64'(in_data.doc_id));
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '{status: mqfc_pkg::ST_OK, printed_doc: '0, queue_length: '0};
        state_nxt = S_DONE;
        k_nxt     = '0;
        found_nxt = 1'b0;
        if (q_ok_r) begin
          unique case (mode_r)
            mqfc_pkg::MODE_ENQ: begin
              if (cnt_cur >= CW'(QUEUE_DEPTH)) begin
                res_nxt.status       = mqfc_pkg::ST_FULL;
                res_nxt.queue_length = 4'(cnt_cur);
              end else begin
                ram_we               = 1'b1;
                cnt_we               = 1'b1;
                cnt_wdata            = CW'(cnt_cur + 1'b1);
                res_nxt.queue_length = 4'(CW'(cnt_cur + 1'b1));
              end
            end
            mqfc_pkg::MODE_PRINT: begin
              if (cnt_cur == '0) begin
                res_nxt.status = mqfc_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            mqfc_pkg::MODE_CANCEL: begin
              if (cnt_cur == '0) begin
                res_nxt.status = mqfc_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            mqfc_pkg::MODE_CLEAR: begin
              cnt_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one read issued per cycle; its data lands in the next cycle
        if (k_r < cnt_cur) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = k_r[KW-1:0];
          k_nxt      = CW'(k_r + 1'b1);
        end
        if (hit) begin
          found_nxt = 1'b1;
          taken_nxt = ram_rdata;
        end
        // past the match: slide each entry down one slot
        if (rd_vld_r && found_r) begin
          ram_we    = 1'b1;
          ram_waddr = base + AW'(rd_idx_r - KW'(1));
          ram_wdata = ram_rdata;
        end
        if (scan_done) begin
          state_nxt = S_DONE;
          if (found_now) begin
            cnt_we    = 1'b1;
            cnt_wdata = CW'(cnt_cur - 1'b1);
            res_nxt.status       = mqfc_pkg::ST_OK;
            res_nxt.queue_length = 4'(CW'(cnt_cur - 1'b1));
            res_nxt.printed_doc  = (mode_r == mqfc_pkg::MODE_PRINT) ?
                                   32'(64'(head_id)) : '0;
          end else begin
            res_nxt.status       = mqfc_pkg::ST_NOT_FOUND;
            res_nxt.printed_doc  = '0;
            res_nxt.queue_length = 4'(cnt_cur);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      if (cnt_we) begin
        cnt_r[q_r] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    q_r        <= q_nxt;
    q_ok_r     <= q_ok_nxt;
    id_r       <= id_nxt;
    k_r        <= k_nxt;
    rd_idx_r   <= rd_idx_nxt;
    found_r    <= found_nxt;
    taken_r    <= taken_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_IMP(a_cnt_bound, clk, !rst_n, state_r == S_EXEC && q_ok_r, cnt_cur <= CW'(QUEUE_DEPTH))
  `ASSERT_IMP(a_print_hits, clk, !rst_n, state_r == S_SCAN && scan_done && mode_r == mqfc_pkg::MODE_PRINT, found_now)
  `ASSERT_IMP(a_we_state, clk, !rst_n, ram_we, state_r == S_EXEC || state_r == S_SCAN)
  `ASSERT_NXT(a_out_load, clk, !rst_n, state_r == S_DONE && (!out_valid_r || out_ready), out_valid_r && state_r == S_IDLE)

endmodule
